// ----- src/sliding_window_burst_detector_defines.svh -----
// assertion helpers for the burst detector
`ifndef SLIDING_WINDOW_BURST_DETECTOR_DEFINES_SVH
`define SLIDING_WINDOW_BURST_DETECTOR_DEFINES_SVH

// checked only outside reset
`define SWBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SWBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/swbd_pkg.sv -----
package swbd_pkg;

  // field widths
  localparam int unsigned TimeW      = 64;
  localparam int unsigned ThresholdW = 16;
  localparam int unsigned NsPerMsW   = 20;
  localparam int unsigned LimitNsW   = ThresholdW + NsPerMsW;

  // nanoseconds in one millisecond
  localparam logic [NsPerMsW-1:0] NsPerMs = NsPerMsW'(1000000);

  typedef logic [TimeW-1:0]      time_ns_t;
  typedef logic [ThresholdW-1:0] threshold_ms_t;
  typedef logic [LimitNsW-1:0]   limit_ns_t;

endpackage

// ----- src/swbd_ring.sv -----
module swbd_ring
  import swbd_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  time_ns_t                 wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output time_ns_t                 rd_data_o
);

  time_ns_t mem_q [DEPTH];
  time_ns_t rd_data_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // one read port, registered data held between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/sliding_window_burst_detector.sv -----
// Burst detector over the last WINDOW_EVENTS event timestamps. One event is taken per clock
// cycle while the output is not held off. At the input transfer edge the oldest timestamp is
// read from the ring memory (one write port, one read port) into a register beside the event;
// then, once the output register is free, the 64-bit subtract and window compare are loaded into
// it, so each result passes through the first stage register and then the output register. A
// stalled output holds the result and stalls the input once the first stage is full.
// The threshold write is scaled to nanoseconds by a multiplier at the register itself, so it
// costs no time per event.
// A zero threshold disables detection: events leave the state alone and report no burst.
`include "sliding_window_burst_detector_defines.svh"

module sliding_window_burst_detector
  import swbd_pkg::*;
#(
  parameter int unsigned WINDOW_EVENTS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  threshold_ms_t threshold_ms_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  time_ns_t      event_time_ns_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          burst_started_o,
  output logic          burst_level_o
);

  localparam int unsigned HeadW = $clog2(WINDOW_EVENTS);
  localparam int unsigned FillW = $clog2(WINDOW_EVENTS + 1);
  localparam logic [HeadW-1:0] HeadLast   = HeadW'(WINDOW_EVENTS - 1);
  localparam logic [FillW-1:0] FillFull   = FillW'(WINDOW_EVENTS);
  localparam logic [FillW-1:0] FillAlmost = FillW'(WINDOW_EVENTS - 1);

  limit_ns_t        limit_ns_q;
  logic [HeadW-1:0] head_q, head_d, head_nxt;
  logic [FillW-1:0] fill_q, fill_d;
  logic             burst_on_q, burst_on_d;
  logic             s1_valid_q, s1_en_q, s1_full_q;
  time_ns_t         s1_now_q;
  time_ns_t         oldest;
  logic             out_valid_q, out_started_q, out_level_q;
  logic             det_en, in_xfer, advance, ring_wr;
  time_ns_t         age;
  logic             hit, level_new;

  // threshold register, kept in nanoseconds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_ns_q <= '0;
    end else if (cfg_we_i) begin
      limit_ns_q <= LimitNsW'(threshold_ms_i) * LimitNsW'(NsPerMs);
    end
  end

  assign det_en = (limit_ns_q != '0);

  // handshake: the first stage moves on whenever the output register is free
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign ring_wr    = in_xfer && det_en;

  // ring pointer and fill level
  assign head_nxt = (head_q == HeadLast) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (ring_wr) begin
      head_d = head_nxt;
      if (fill_q != FillFull) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // timestamp ring; once full, the slot after the head holds the oldest entry
  swbd_ring #(
    .DEPTH(WINDOW_EVENTS)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (ring_wr),
    .wr_addr_i(head_q),
    .wr_data_i(event_time_ns_i),
    .rd_en_i  (in_xfer),
    .rd_addr_i(head_nxt),
    .rd_data_o(oldest)
  );

  // first stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer || (s1_valid_q && !advance);
    end
  end

  // first stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_now_q  <= event_time_ns_i;
      s1_en_q   <= det_en;
      s1_full_q <= (fill_q >= FillAlmost);
    end
  end

  // window check on the oldest timestamp
  assign age       = s1_now_q - oldest;
  assign hit       = (age <= TimeW'(limit_ns_q));
  assign level_new = s1_full_q && hit;

  always_comb begin
    burst_on_d = burst_on_q;
    if (s1_valid_q && advance && s1_en_q) begin
      burst_on_d = level_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_on_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      burst_on_q <= burst_on_d;
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      out_level_q   <= s1_en_q && level_new;
      out_started_q <= s1_en_q && level_new && !burst_on_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign burst_started_o = out_started_q;
  assign burst_level_o   = out_level_q;

  // checks
  `SWBD_ASSERT_ALWAYS(a_fill_range, fill_q <= FillFull, "fill count beyond ring depth")
  `SWBD_ASSERT(a_disabled_keeps_head, (in_xfer && !det_en) |=> $stable(head_q), "head moved")
  `SWBD_ASSERT(a_start_implies_level, (out_valid_o && burst_started_o) |-> burst_level_o, "start")
  `SWBD_ASSERT(a_level_matches_state, (out_valid_o && burst_level_o) |-> burst_on_q, "level off")
  `SWBD_ASSERT(a_stage_holds, (s1_valid_q && !advance) |=> s1_valid_q, "first stage lost an item")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench
  import swbd_pkg::*;
();

  localparam int unsigned WINDOW_EVENTS = 8;
  localparam time_ns_t    NS_IN_MS      = 64'd1_000_000;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam int unsigned RANDOM_EVENTS = 2000;

  // one result transfer
  typedef struct packed {
    logic started;
    logic level;
  } burst_result_t;

  // block ports
  logic          clk_i           = 1'b0;
  logic          rst_ni          = 1'b1;
  logic          cfg_we_i        = 1'b0;
  threshold_ms_t threshold_ms_i  = '0;
  logic          in_valid_i      = 1'b0;
  logic          in_stall_o;
  time_ns_t      event_time_ns_i = '0;
  logic          out_valid_o;
  logic          out_stall_i     = 1'b0;
  logic          burst_started_o;
  logic          burst_level_o;

  // detector state as the testbench tracks it
  time_ns_t      seen_times [WINDOW_EVENTS];
  int unsigned   slot_next      = 0;
  int unsigned   slots_filled   = 0;
  logic          model_burst    = 1'b0;
  threshold_ms_t window_setting = '0;

  // results still owed by the block, oldest first
  burst_result_t owed_results [$];

  // run statistics
  int unsigned error_count   = 0;
  int unsigned events_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned onsets_seen   = 0;
  int unsigned levels_seen   = 0;
  int unsigned setting_count = 0;
  int unsigned cycle_count   = 0;

  // idling controls
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned stall_run = 0;

  sliding_window_burst_detector #(
    .WINDOW_EVENTS(WINDOW_EVENTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .threshold_ms_i (threshold_ms_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .event_time_ns_i(event_time_ns_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .burst_started_o(burst_started_o),
    .burst_level_o  (burst_level_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               owed_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure: short stalls mostly, an occasional long one
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= stall_run - 1;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare every result transfer with the oldest owed result
  always @(posedge clk_i) begin
    burst_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (burst_started_o === 1'b1) onsets_seen++;
      if (burst_level_o === 1'b1) levels_seen++;
      if (owed_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with none expected, expected nothing, got started %0b level %0b",
                   $time, burst_started_o, burst_level_o);
      end else begin
        want = owed_results.pop_front();
        if (burst_started_o !== want.started) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: burst_started mismatch, expected %0b, got %0b", $time, want.started,
                     burst_started_o);
        end
        if (burst_level_o !== want.level) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: burst_level mismatch, expected %0b, got %0b", $time, want.level,
                     burst_level_o);
        end
      end
    end
  end

  // work out the result of one event and update the tracked state
  function automatic burst_result_t next_burst_result(input time_ns_t stamp);
    burst_result_t res;
    time_ns_t      span_ns;
    time_ns_t      oldest;
    logic          was_active;
    res = '0;
    // detection off: nothing recorded, nothing reported
    if (window_setting == '0) return res;
    span_ns    = time_ns_t'(window_setting) * NS_IN_MS;
    was_active = model_burst;
    seen_times[slot_next] = stamp;
    slot_next = (slot_next + 1) % WINDOW_EVENTS;
    if (slots_filled < WINDOW_EVENTS) slots_filled++;
    // full ring: compare the span back to the oldest stored event, modulo 2^64
    if (slots_filled == WINDOW_EVENTS) begin
      oldest      = seen_times[slot_next];
      model_burst = (stamp - oldest) <= span_ns;
    end else begin
      model_burst = 1'b0;
    end
    res.started = model_burst & ~was_active;
    res.level   = model_burst;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one event transfer, with a random idle gap ahead of it
  task automatic send_event(input time_ns_t stamp);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    event_time_ns_i <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    owed_results.push_back(next_burst_result(stamp));
    events_sent++;
  endtask

  // stop sending and wait for every owed result, then let the pipeline settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input threshold_ms_t value);
    drain_results();
    cfg_we_i       <= 1'b1;
    threshold_ms_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    window_setting = value;
    setting_count++;
  endtask

  // threshold left at its reset value: detection off, extremes of the timestamp
  task automatic test_disabled_after_reset();
    send_event('0);
    send_event('1);
  endtask

  // ring filling up, then spans exactly at and one past the window
  task automatic test_window_boundary();
    time_ns_t base;
    base = 64'd1000;
    write_threshold(16'd1);
    for (int i = 0; i < 7; i++) send_event(base + time_ns_t'(i * 10));
    send_event(base + NS_IN_MS);
    send_event(base + 64'd10 + NS_IN_MS + 64'd1);
    send_event(base + 64'd20 + NS_IN_MS);
  endtask

  // timestamps running through 2^64 and back to zero, widest window
  task automatic test_time_wrap();
    write_threshold(16'hFFFF);
    for (int i = 0; i < 8; i++) send_event(time_ns_t'(64'hFFFF_FFFF_FFFF_FFFC + i));
  endtask

  // turning detection off keeps the ring and the burst level as they were
  task automatic test_disable_holds_state();
    write_threshold('0);
    send_event('1);
    write_threshold(16'hFFFF);
    send_event(64'd4);
  endtask

  // timestamps stepping back behind the oldest stored one
  task automatic test_time_backwards();
    send_event(64'd4 - 64'd1000);
    send_event(64'd4 - 64'd2004);
  endtask

  function automatic threshold_ms_t pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'd1;
    return threshold_ms_t'($urandom_range(1, 65535));
  endfunction

  function automatic time_ns_t pick_start_time();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1 - time_ns_t'($urandom_range(0, 1_000_000_000));
    return {$urandom(), $urandom()};
  endfunction

  // phases at random thresholds: mostly event runs spaced around the window, plus noise
  task automatic test_random_traffic(input int unsigned count);
    int unsigned   target;
    int unsigned   phase_end;
    int unsigned   run_len;
    int unsigned   centre;
    int unsigned   pick;
    threshold_ms_t thr;
    time_ns_t      span_ns;
    time_ns_t      stamp;
    time_ns_t      step;
    target = events_sent + count;
    while (events_sent < target) begin
      thr = pick_threshold();
      write_threshold(thr);
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      span_ns   = time_ns_t'(thr) * NS_IN_MS;
      stamp     = pick_start_time();
      phase_end = events_sent + $urandom_range(120, 260);
      while (events_sent < phase_end && events_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // seven steps span the window when the spacing is about 18/128 of it
          run_len = $urandom_range(8, 40);
          centre  = $urandom_range(8, 28);
          repeat (run_len) begin
            step  = (span_ns >> 7) * time_ns_t'($urandom_range(centre - 4, centre + 4))
                    + time_ns_t'($urandom_range(0, 3));
            stamp = stamp + step;
            send_event(stamp);
          end
        end else if (pick < 92) begin
          stamp = {$urandom(), $urandom()};
          send_event(stamp);
        end else begin
          stamp = stamp - ((span_ns >> 3) * time_ns_t'($urandom_range(1, 16)) + 64'd1);
          send_event(stamp);
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // test sequence
  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_after_reset();
    test_window_boundary();
    test_time_wrap();
    test_disable_holds_state();
    test_time_backwards();
    test_random_traffic(RANDOM_EVENTS);

    drain_results();
    repeat (20) @(posedge clk_i);

    $display("run covered %0d events over %0d threshold settings", events_sent, setting_count);
    $display("%0d results checked, %0d burst onsets, %0d with burst level high, %0d errors",
             results_seen, onsets_seen, levels_seen, error_count);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sliding_window_burst_detector.f -----
+incdir+src
src/swbd_pkg.sv
src/swbd_ring.sv
src/sliding_window_burst_detector.sv
test/testbench.sv
